// ===== hw/rtl/prefix_code_table_decoder_assert.svh =====
// Assertion macros for the prefix code table decoder checker.
// Depends on nothing; taken in by the checker file.
`ifndef PREFIX_CODE_TABLE_DECODER_ASSERT_SVH
`define PREFIX_CODE_TABLE_DECODER_ASSERT_SVH

// same-cycle implication
`define PCTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pctd: implication check failed");

// next-cycle implication
`define PCTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pctd: next-cycle check failed");

`endif

// ===== hw/rtl/pctd_pkg.sv =====
// Shared types, constants and helpers for the prefix code table decoder.
// No dependencies.
package pctd_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int ACC_W        = 32;
  localparam int LEN_W        = 6;
  localparam int IDX_W        = 8;
  localparam int SYM_W        = 8;
  localparam int BYTE_W       = 8;
  localparam int CODE_LIMIT   = (MAX_CODE_LEN < ACC_W) ? MAX_CODE_LEN : ACC_W;

  // table is split into a row of cells, each holding a few entries
  localparam int CELL_ENTRIES = 8;
  localparam int SLOT_W       = $clog2(CELL_ENTRIES);
  localparam int NUM_CELLS    = (TABLE_DEPTH + CELL_ENTRIES - 1) / CELL_ENTRIES;
  localparam int CELL_W       = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  localparam logic [IDX_W:0]   DEPTH_LIM = (IDX_W + 1)'(TABLE_DEPTH);
  localparam logic [LEN_W-1:0] LIMIT_LEN = LEN_W'(CODE_LIMIT);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  entry_index;
    logic [LEN_W-1:0]  entry_length;
    logic [ACC_W-1:0]  entry_code;
    logic [SYM_W-1:0]  entry_symbol;
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             no_match_error;
    logic             last;
  } out_item_t;

  // table write broadcast to the cells
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
    logic [ACC_W-1:0]  code;
    logic [SYM_W-1:0]  symbol;
  } wr_t;

  // accumulated code broadcast to the cells
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [ACC_W-1:0] bits;
  } key_t;

  // match result passed from cell to cell, lowest index first
  typedef struct packed {
    logic             found;
    logic [SYM_W-1:0] symbol;
  } chain_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_FLUSH
  } state_t;

  function automatic logic [ACC_W-1:0] code_mask(input logic [LEN_W-1:0] len);
    logic [ACC_W-1:0] m;
    if (len >= LEN_W'(ACC_W)) begin
      m = '1;
    end else begin
      m = (ACC_W'(1) << len) - ACC_W'(1);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/prefix_code_table_decoder.sv =====
// Top level of the prefix code table decoder: a row of table cells and the
// bit sequencer. Uses pctd_pkg, pctd_cell and pctd_seq.
//
//   channel   ports                      handshake
//   input     start, busy, in_item       taken when start=1 and busy=0
//   result    out_strobe, out_item       one cycle per item, no backpressure
//
// Load items write one table entry in the accept cycle; busy stays low.
// Decode items step through each bit as the cell compare register, then the
// priority merge along the cell chain, and end with a flush state; busy stays
// high until the flush is done, so a new item is taken only after that.
// Each result is held until the next one of the same item settles, or until
// the flush cycle for the last one, and then leaves from a register in the following cycle.
// Reset is synchronous: it clears entry valid bits, the accumulator and the
// sequencer; table payload is left as is. The receiver cannot stall.
module prefix_code_table_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pctd_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output pctd_pkg::out_item_t out_item
);

  pctd_pkg::key_t   key;
  pctd_pkg::wr_t    wr;
  pctd_pkg::chain_t chain [pctd_pkg::NUM_CELLS+1];
  logic                        wr_go;
  logic [pctd_pkg::CELL_W-1:0] cell_sel;

  // loads outside the table are dropped
  assign wr_go = start && !busy && (in_item.func == pctd_pkg::FUNC_LOAD) &&
                 ({1'b0, in_item.entry_index} < pctd_pkg::DEPTH_LIM);

  assign cell_sel  = pctd_pkg::CELL_W'(in_item.entry_index >> pctd_pkg::SLOT_W);
  assign wr.slot   = in_item.entry_index[pctd_pkg::SLOT_W-1:0];
  assign wr.length = in_item.entry_length;
  assign wr.code   = in_item.entry_code;
  assign wr.symbol = in_item.entry_symbol;

  // head of the chain: nothing found yet
  assign chain[0] = '0;

  for (genvar k = 0; k < pctd_pkg::NUM_CELLS; k++) begin : g_cell
    pctd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_go && (cell_sel == pctd_pkg::CELL_W'(k))),
      .wr        (wr),
      .key       (key),
      .chain_in  (chain[k]),
      .chain_out (chain[k+1])
    );
  end

  pctd_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .key        (key),
    .chain_res  (chain[pctd_pkg::NUM_CELLS]),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== hw/rtl/pctd_cell.sv =====
// One table cell: holds CELL_ENTRIES entries, matches them against the key
// and merges its registered hit into the neighbor chain. Uses pctd_pkg.
module pctd_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  pctd_pkg::wr_t    wr,
  input  pctd_pkg::key_t   key,
  input  pctd_pkg::chain_t chain_in,
  output pctd_pkg::chain_t chain_out
);

  logic [pctd_pkg::CELL_ENTRIES-1:0] valid_r;
  logic [pctd_pkg::LEN_W-1:0] len_r  [pctd_pkg::CELL_ENTRIES];
  logic [pctd_pkg::ACC_W-1:0] code_r [pctd_pkg::CELL_ENTRIES];
  logic [pctd_pkg::SYM_W-1:0] sym_r  [pctd_pkg::CELL_ENTRIES];

  logic                       hit_r, hit_nxt;
  logic [pctd_pkg::SYM_W-1:0] hsym_r, hsym_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr.slot] <= (wr.length != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr.length != '0)) begin
      len_r[wr.slot]  <= wr.length;
      code_r[wr.slot] <= wr.code & pctd_pkg::code_mask(wr.length);
      sym_r[wr.slot]  <= wr.symbol;
    end
  end

  // lowest slot wins inside the cell
  always_comb begin
    hit_nxt  = 1'b0;
    hsym_nxt = '0;
    for (int i = pctd_pkg::CELL_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (len_r[i] == key.length) && (code_r[i] == key.bits)) begin
        hit_nxt  = 1'b1;
        hsym_nxt = sym_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hsym_r <= hsym_nxt;
  end

  // earlier cells take priority
  assign chain_out.found  = chain_in.found | hit_r;
  assign chain_out.symbol = chain_in.found ? chain_in.symbol : hsym_r;

endmodule

// ===== hw/rtl/pctd_seq.sv =====
// Bit sequencer: accumulator, bit stepping, result hold and output register.
// Uses pctd_pkg; reads the merged result at the end of the cell chain.
module pctd_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pctd_pkg::in_item_t  in_item,
  output logic                busy,
  output pctd_pkg::key_t      key,
  input  pctd_pkg::chain_t    chain_res,
  output logic                out_strobe,
  output pctd_pkg::out_item_t out_item
);

  pctd_pkg::state_t state_r, state_nxt;

  logic [pctd_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [pctd_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [pctd_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic [2:0]                  bit_r, bit_nxt;
  logic [2:0]                  lastbit_r, lastbit_nxt;
  logic                        final_r, final_nxt;
  logic                        held_vld_r, held_vld_nxt;
  pctd_pkg::out_item_t         held_r, held_nxt;
  logic                        out_vld_r, out_vld_nxt;
  pctd_pkg::out_item_t         out_r, out_nxt;

  logic                        dec_go;
  logic                        emit;
  logic                        bit_done;
  pctd_pkg::out_item_t         new_res;
  logic [pctd_pkg::ACC_W-1:0]  base_acc;
  logic [pctd_pkg::LEN_W-1:0]  base_len;

  assign busy     = (state_r != pctd_pkg::ST_IDLE);
  assign dec_go   = start && !busy && (in_item.func == pctd_pkg::FUNC_DECODE);
  assign emit     = (state_r == pctd_pkg::ST_RESOLVE) &&
                    (chain_res.found || (len_r >= pctd_pkg::LIMIT_LEN));
  assign bit_done = (bit_r == lastbit_r);
  assign base_acc = emit ? '0 : acc_r;
  assign base_len = emit ? '0 : len_r;

  assign new_res.symbol         = chain_res.found ? chain_res.symbol : '0;
  assign new_res.no_match_error = !chain_res.found;
  assign new_res.last           = 1'b0;

  assign key.length = len_r;
  assign key.bits   = acc_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pctd_pkg::ST_IDLE:    if (dec_go) state_nxt = pctd_pkg::ST_MATCH;
      pctd_pkg::ST_MATCH:   state_nxt = pctd_pkg::ST_RESOLVE;
      pctd_pkg::ST_RESOLVE: state_nxt = bit_done ? pctd_pkg::ST_FLUSH : pctd_pkg::ST_MATCH;
      pctd_pkg::ST_FLUSH:   state_nxt = pctd_pkg::ST_IDLE;
      default:              state_nxt = pctd_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    acc_nxt      = acc_r;
    len_nxt      = len_r;
    byte_nxt     = byte_r;
    bit_nxt      = bit_r;
    lastbit_nxt  = lastbit_r;
    final_nxt    = final_r;
    held_vld_nxt = held_vld_r;
    held_nxt     = held_r;
    out_vld_nxt  = 1'b0;
    out_nxt      = held_r;
    case (state_r)
      pctd_pkg::ST_IDLE: begin
        if (dec_go) begin
          acc_nxt     = {acc_r[pctd_pkg::ACC_W-2:0], in_item.data_byte[pctd_pkg::BYTE_W-1]};
          len_nxt     = len_r + pctd_pkg::LEN_W'(1);
          byte_nxt    = {in_item.data_byte[pctd_pkg::BYTE_W-2:0], 1'b0};
          bit_nxt     = '0;
          lastbit_nxt = in_item.final_byte ? 3'd6 : 3'd7;
          final_nxt   = in_item.final_byte;
        end
      end
      pctd_pkg::ST_RESOLVE: begin
        if (!bit_done) begin
          acc_nxt  = {base_acc[pctd_pkg::ACC_W-2:0], byte_r[pctd_pkg::BYTE_W-1]};
          len_nxt  = base_len + pctd_pkg::LEN_W'(1);
          byte_nxt = {byte_r[pctd_pkg::BYTE_W-2:0], 1'b0};
          bit_nxt  = bit_r + 3'd1;
        end else if (final_r) begin
          acc_nxt = '0;
          len_nxt = '0;
        end else begin
          acc_nxt = base_acc;
          len_nxt = base_len;
        end
        if (emit) begin
          // older held result goes out; it cannot be the item's last
          out_vld_nxt      = held_vld_r;
          out_nxt          = held_r;
          out_nxt.last     = 1'b0;
          held_vld_nxt     = 1'b1;
          held_nxt         = new_res;
        end
      end
      pctd_pkg::ST_FLUSH: begin
        out_vld_nxt  = held_vld_r;
        out_nxt      = held_r;
        out_nxt.last = 1'b1;
        held_vld_nxt = 1'b0;
      end
      default: begin
        out_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pctd_pkg::ST_IDLE;
      acc_r      <= '0;
      len_r      <= '0;
      held_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      acc_r      <= acc_nxt;
      len_r      <= len_nxt;
      held_vld_r <= held_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    bit_r     <= bit_nxt;
    lastbit_r <= lastbit_nxt;
    final_r   <= final_nxt;
    held_r    <= held_nxt;
    out_r     <= out_nxt;
  end

  assign out_strobe = out_vld_r;
  assign out_item   = out_r;

endmodule

// ===== hw/rtl/pctd_checker.sv =====
// Port-level checks for the prefix code table decoder, bound to the top.
// Uses pctd_pkg and prefix_code_table_decoder_assert.svh.
`include "prefix_code_table_decoder_assert.svh"

module pctd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input pctd_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input pctd_pkg::out_item_t out_item
);

  `PCTD_ASSERT_IMP(a_err_zero_sym, clk, rst_n, out_strobe && out_item.no_match_error, out_item.symbol == '0)
  `PCTD_ASSERT_NXT(a_dec_busy, clk, rst_n, start && !busy && in_item.func == pctd_pkg::FUNC_DECODE, busy)
  `PCTD_ASSERT_NXT(a_load_fast, clk, rst_n, start && !busy && in_item.func == pctd_pkg::FUNC_LOAD, !busy)
  `PCTD_ASSERT_NXT(a_last_gap, clk, rst_n, out_strobe && out_item.last, !out_strobe)

endmodule

bind prefix_code_table_decoder pctd_checker u_pctd_checker (.*);
